// ===== design/graph_local_moving_community_core_assert.svh =====
// Assertion macros shared by the community core.
`ifndef GRAPH_LOCAL_MOVING_COMMUNITY_CORE_ASSERT_SVH
`define GRAPH_LOCAL_MOVING_COMMUNITY_CORE_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define GLMC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that one condition implies another on the following edge.
`define GLMC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/glmc_pkg.sv =====
// Package with constants, codes and state types of the community core.
`default_nettype none
package glmc_pkg;
  localparam int NODES       = 256;
  localparam int EDGES       = 1024;
  localparam int VISIT_LIMIT = 64 * NODES;
  localparam int NODE_W      = 8;
  localparam int CNT_W       = 9;
  localparam int EIDX_W      = 10;
  localparam int ETOT_W      = 11;
  localparam int DEG_W       = 12;
  localparam int VIS_W       = 15;
  localparam int PROD_W      = 44;
  localparam int SCORE_W     = 46;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NODE = 2'd2
  } status_t;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_GAMMA      = 2'd1;
  localparam logic [1:0] REG_RESOLUTION = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE, S_QRY, S_DONE, S_ZERO, S_INIT,
    S_DG_RD, S_DG_E, S_DG_A, S_DG_B0, S_DG_B,
    S_CW_RD, S_CW_C, S_CW_W,
    S_POP, S_POP_N, S_POP_C,
    S_SCAN_RD, S_SCAN_E, S_SCAN_CHK, S_SCAN_NXT,
    S_T_C, S_T_CHK, S_R_C,
    S_SC0, S_SC1, S_SC2, S_SC3, S_CL_RD, S_CL_C,
    S_MV, S_MV1, S_MV2, S_MV3
  } state_t;
endpackage
`default_nettype wire

// ===== design/graph_local_moving_community_core.sv =====
// Top level of the community core: edge store, local moving sequencer and queries.
//
//  Channel   Signals                                Direction  Contents
//  s         s_tvalid s_tready s_tdata s_tuser      in         mode, node_a, node_b
//  m         m_tvalid m_tready m_tdata m_tuser      out        status, value
//  cfg       cfg_valid cfg_ready cfg_index cfg_data in         register writes
//
// Add edge and rejected items give their result in the cycle after acceptance; a query
// reads the membership memory in S_QRY and gives its result from S_DONE. A clear answers
// at once, then rewrites every entry of the membership memory; the same pass runs after
// reset, with s_tready low. A run zeroes the node tables, rebuilds degrees from the edges
// in range and weights per node, then for each of up to 16384 dequeues walks every
// stored edge and scores each candidate; a move adds another edge walk.
// A result waiting on m holds off the input side until it is taken.
`default_nettype none
module graph_local_moving_community_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // node_a [7:0], node_b [15:8]
  input  wire logic [1:0]  s_tuser,   // mode [1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // value [15:0]
  output logic [1:0]       m_tuser,   // status [1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import glmc_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]   node_count;
  logic [31:0]        gamma, resolution;
  logic [ETOT_W-1:0]  edge_total, edge_total_next;
  logic [ETOT_W-1:0]  k, k_next;
  logic [CNT_W-1:0]   i, i_next;
  logic [NODE_W-1:0]  q_head, q_head_next;
  logic [CNT_W-1:0]   q_len, q_len_next;
  logic [CNT_W-1:0]   cand_len, cand_len_next;
  logic [VIS_W-1:0]   visits, visits_next;
  logic [15:0]        moves, moves_next;
  logic [NODE_W-1:0]  node, node_next, cur, cur_next, best, best_next;
  logic [NODE_W-1:0]  ea, ea_next, eb, eb_next, tc, tc_next;
  logic [DEG_W-1:0]   ndeg, ndeg_next, dtmp, dtmp_next;
  logic [DEG_W-1:0]   mcount, mcount_next, mweight, mweight_next;
  logic [PROD_W-1:0]  prod, prod_next;
  logic signed [SCORE_W-1:0] best_score, best_score_next;
  logic               side, side_next, rq, rq_next, cur_phase, cur_phase_next;
  logic               m_tvalid_next;
  logic [15:0]        m_tdata_next, res_value, res_value_next;
  logic [1:0]         m_tuser_next, res_status, res_status_next;

  logic [CNT_W-1:0]   n_act;
  logic               out_free, in_range;
  logic [NODE_W-1:0]  in_a, in_b;

  // Memory ports.
  logic               edge_we;
  logic [EIDX_W-1:0]  edge_waddr, edge_raddr;
  logic [15:0]        edge_wdata, edge_rdata;
  logic               comm_we;
  logic [NODE_W-1:0]  comm_waddr, comm_raddr, comm_wdata, comm_rdata;
  logic [NODE_W-1:0]  comm_val;
  logic               deg_we;
  logic [NODE_W-1:0]  deg_waddr, deg_raddr;
  logic [DEG_W-1:0]   deg_wdata, deg_rdata;
  logic               cw_we;
  logic [NODE_W-1:0]  cw_waddr, cw_raddr;
  logic [DEG_W-1:0]   cw_wdata, cw_rdata;
  logic               etc_we;
  logic [NODE_W-1:0]  etc_waddr, etc_raddr;
  logic [DEG_W-1:0]   etc_wdata, etc_rdata;
  logic               cand_we;
  logic [NODE_W-1:0]  cand_waddr, cand_raddr, cand_wdata, cand_rdata;
  logic               queue_we;
  logic [NODE_W-1:0]  queue_waddr, queue_raddr, queue_wdata, queue_rdata;
  logic               seen_we, seen_wdata, seen_rdata;
  logic [NODE_W-1:0]  seen_waddr, seen_raddr;
  logic               queued_we, queued_wdata, queued_rdata;
  logic [NODE_W-1:0]  queued_waddr, queued_raddr;

  logic [15:0]        edge_mem   [EDGES];
  logic [NODE_W-1:0]  comm_mem   [NODES];
  logic [DEG_W-1:0]   deg_mem    [NODES];
  logic [DEG_W-1:0]   cw_mem     [NODES];
  logic [DEG_W-1:0]   etc_mem    [NODES];
  logic [NODE_W-1:0]  cand_mem   [NODES];
  logic [NODE_W-1:0]  queue_mem  [NODES];
  logic               seen_mem   [NODES];
  logic               queued_mem [NODES];

  logic signed [SCORE_W-1:0] score;
  logic signed [SCORE_W:0]   thresh;

  assign n_act     = (node_count > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign cfg_ready = 1'b1;
  assign in_a      = s_tdata[7:0];
  assign in_b      = s_tdata[15:8];
  assign comm_val  = comm_rdata;
  assign in_range  = ({1'b0, ea} < n_act) && ({1'b0, eb} < n_act);
  assign score     = $signed({10'b0, mcount, 24'b0}) - $signed({2'b0, prod});
  assign thresh    = {best_score[SCORE_W-1], best_score} + $signed({15'b0, resolution});

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rdata <= edge_mem[edge_raddr];
    if (comm_we) comm_mem[comm_waddr] <= comm_wdata;
    comm_rdata <= comm_mem[comm_raddr];
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    deg_rdata <= deg_mem[deg_raddr];
    if (cw_we) cw_mem[cw_waddr] <= cw_wdata;
    cw_rdata <= cw_mem[cw_raddr];
    if (etc_we) etc_mem[etc_waddr] <= etc_wdata;
    etc_rdata <= etc_mem[etc_raddr];
    if (cand_we) cand_mem[cand_waddr] <= cand_wdata;
    cand_rdata <= cand_mem[cand_raddr];
    if (queue_we) queue_mem[queue_waddr] <= queue_wdata;
    queue_rdata <= queue_mem[queue_raddr];
    if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
    seen_rdata <= seen_mem[seen_raddr];
    if (queued_we) queued_mem[queued_waddr] <= queued_wdata;
    queued_rdata <= queued_mem[queued_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      i          <= '0;
      node_count <= CNT_W'(NODES);
      gamma      <= 32'd16777216;
      resolution <= 32'd16777;
      edge_total <= '0;
      q_len      <= '0;
      cand_len   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      i          <= i_next;
      edge_total <= edge_total_next;
      q_len      <= q_len_next;
      cand_len   <= cand_len_next;
      m_tvalid   <= m_tvalid_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NODE_COUNT: node_count <= cfg_data[CNT_W-1:0];
          REG_GAMMA:      gamma      <= cfg_data;
          REG_RESOLUTION: resolution <= cfg_data;
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    k          <= k_next;
    q_head     <= q_head_next;
    visits     <= visits_next;
    moves      <= moves_next;
    node       <= node_next;
    cur        <= cur_next;
    best       <= best_next;
    ea         <= ea_next;
    eb         <= eb_next;
    tc         <= tc_next;
    ndeg       <= ndeg_next;
    dtmp       <= dtmp_next;
    mcount     <= mcount_next;
    mweight    <= mweight_next;
    prod       <= prod_next;
    best_score <= best_score_next;
    side       <= side_next;
    rq         <= rq_next;
    cur_phase  <= cur_phase_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
  end

  always_comb begin
    state_next      = state;
    edge_total_next = edge_total;
    k_next          = k;
    i_next          = i;
    q_head_next     = q_head;
    q_len_next      = q_len;
    cand_len_next   = cand_len;
    visits_next     = visits;
    moves_next      = moves;
    node_next       = node;
    cur_next        = cur;
    best_next       = best;
    ea_next         = ea;
    eb_next         = eb;
    tc_next         = tc;
    ndeg_next       = ndeg;
    dtmp_next       = dtmp;
    mcount_next     = mcount;
    mweight_next    = mweight;
    prod_next       = prod;
    best_score_next = best_score;
    side_next       = side;
    rq_next         = rq;
    cur_phase_next  = cur_phase;
    res_value_next  = res_value;
    res_status_next = res_status;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;

    edge_we = 1'b0;  edge_waddr = edge_total[EIDX_W-1:0];
    edge_wdata = {in_a, in_b};  edge_raddr = k[EIDX_W-1:0];
    comm_we = 1'b0;  comm_waddr = node;  comm_wdata = best;
    comm_raddr = side ? ea : eb;
    deg_we = 1'b0;  deg_waddr = ea;  deg_wdata = '0;  deg_raddr = ea;
    cw_we = 1'b0;  cw_waddr = cur;  cw_wdata = '0;  cw_raddr = cur;
    etc_we = 1'b0;  etc_waddr = tc;  etc_wdata = '0;  etc_raddr = cur;
    cand_we = 1'b0;  cand_waddr = cand_len[NODE_W-1:0];  cand_wdata = tc;
    cand_raddr = i[NODE_W-1:0];
    queue_we = 1'b0;  queue_waddr = i[NODE_W-1:0];  queue_wdata = i[NODE_W-1:0];
    queue_raddr = q_head;
    seen_we = 1'b0;  seen_waddr = tc;  seen_wdata = 1'b0;  seen_raddr = cur;
    queued_we = 1'b0;  queued_waddr = i[NODE_W-1:0];  queued_wdata = 1'b0;
    queued_raddr = side ? ea : eb;

    unique case (state)
      S_IDLE: begin
        comm_raddr = in_a;
        if (s_tvalid && s_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = '0;
          m_tuser_next  = ST_OK;
          unique case (mode_t'(s_tuser))
            MODE_ADD: begin
              if (({1'b0, in_a} >= n_act) || ({1'b0, in_b} >= n_act)) begin
                m_tuser_next = ST_NODE;
              end else if (edge_total == ETOT_W'(EDGES)) begin
                m_tuser_next = ST_FULL;
              end else begin
                edge_we         = 1'b1;
                edge_total_next = edge_total + 1'b1;
              end
            end
            MODE_RUN: begin
              m_tvalid_next = 1'b0;
              i_next        = '0;
              visits_next   = '0;
              moves_next    = '0;
              state_next    = S_ZERO;
            end
            MODE_QUERY: begin
              if ({1'b0, in_a} >= n_act) begin
                m_tuser_next = ST_NODE;
              end else begin
                m_tvalid_next = 1'b0;
                state_next    = S_QRY;
              end
            end
            MODE_CLEAR: begin
              edge_total_next = '0;
              i_next          = '0;
              state_next      = S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        comm_we    = 1'b1;
        comm_waddr = i[NODE_W-1:0];
        comm_wdata = i[NODE_W-1:0];
        if (i == CNT_W'(NODES - 1)) begin
          state_next = S_IDLE;
        end
        i_next = i + 1'b1;
      end
      S_QRY: begin
        res_status_next = ST_OK;
        res_value_next  = {8'b0, comm_val};
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = res_value;
          m_tuser_next  = res_status;
          state_next    = S_IDLE;
        end
      end
      S_ZERO: begin
        deg_we       = 1'b1;
        deg_waddr    = i[NODE_W-1:0];
        cw_we        = 1'b1;
        cw_waddr     = i[NODE_W-1:0];
        seen_we      = 1'b1;
        seen_waddr   = i[NODE_W-1:0];
        queued_we    = 1'b1;
        if (i == CNT_W'(NODES - 1)) begin
          k_next     = '0;
          state_next = S_DG_RD;
        end
        i_next = i + 1'b1;
      end
      S_DG_RD: begin
        if (k == edge_total) begin
          i_next     = '0;
          state_next = S_CW_RD;
        end else begin
          state_next = S_DG_E;
        end
      end
      S_DG_E: begin
        ea_next    = edge_rdata[15:8];
        eb_next    = edge_rdata[7:0];
        deg_raddr  = edge_rdata[15:8];
        if (({1'b0, edge_rdata[15:8]} < n_act) && ({1'b0, edge_rdata[7:0]} < n_act)) begin
          state_next = S_DG_A;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_DG_RD;
        end
      end
      S_DG_A: begin
        deg_we     = 1'b1;
        deg_waddr  = ea;
        deg_wdata  = deg_rdata + 1'b1;
        state_next = S_DG_B0;
      end
      S_DG_B0: begin
        deg_raddr  = eb;
        state_next = S_DG_B;
      end
      S_DG_B: begin
        deg_we     = 1'b1;
        deg_waddr  = eb;
        deg_wdata  = deg_rdata + 1'b1;
        k_next     = k + 1'b1;
        state_next = S_DG_RD;
      end
      S_CW_RD: begin
        if (i == n_act) begin
          q_head_next = '0;
          q_len_next  = n_act;
          state_next  = S_POP;
        end else begin
          comm_raddr   = i[NODE_W-1:0];
          deg_raddr    = i[NODE_W-1:0];
          queue_we     = 1'b1;
          queued_we    = 1'b1;
          queued_wdata = 1'b1;
          state_next   = S_CW_C;
        end
      end
      S_CW_C: begin
        tc_next    = comm_val;
        dtmp_next  = deg_rdata;
        cw_raddr   = comm_val;
        state_next = S_CW_W;
      end
      S_CW_W: begin
        cw_we      = 1'b1;
        cw_waddr   = tc;
        cw_wdata   = cw_rdata + dtmp;
        i_next     = i + 1'b1;
        state_next = S_CW_RD;
      end
      S_POP: begin
        if ((q_len == '0) || (visits == VIS_W'(VISIT_LIMIT))) begin
          q_len_next      = '0;
          res_status_next = ST_OK;
          res_value_next  = moves;
          state_next      = S_DONE;
        end else begin
          q_head_next = q_head + 1'b1;
          q_len_next  = q_len - 1'b1;
          visits_next = visits + 1'b1;
          state_next  = S_POP_N;
        end
      end
      S_POP_N: begin
        node_next    = queue_rdata;
        queued_we    = 1'b1;
        queued_waddr = queue_rdata;
        comm_raddr   = queue_rdata;
        deg_raddr    = queue_rdata;
        state_next   = S_POP_C;
      end
      S_POP_C: begin
        cur_next      = comm_val;
        ndeg_next     = deg_rdata;
        k_next        = '0;
        cand_len_next = '0;
        rq_next       = 1'b0;
        state_next    = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (k == edge_total) begin
          state_next = rq ? S_POP : S_SC0;
        end else begin
          side_next  = 1'b0;
          state_next = S_SCAN_E;
        end
      end
      S_SCAN_E: begin
        ea_next    = edge_rdata[15:8];
        eb_next    = edge_rdata[7:0];
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (in_range && ((side ? eb : ea) == node)) begin
          tc_next    = side ? ea : eb;
          state_next = rq ? S_R_C : S_T_C;
        end else begin
          state_next = S_SCAN_NXT;
        end
      end
      S_SCAN_NXT: begin
        if (!side) begin
          side_next  = 1'b1;
          state_next = S_SCAN_CHK;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_T_C: begin
        tc_next    = comm_val;
        etc_raddr  = comm_val;
        seen_raddr = comm_val;
        state_next = S_T_CHK;
      end
      S_T_CHK: begin
        etc_we = 1'b1;
        if (seen_rdata) begin
          etc_wdata = etc_rdata + 1'b1;
        end else begin
          etc_wdata     = DEG_W'(1);
          seen_we       = 1'b1;
          seen_wdata    = 1'b1;
          cand_we       = 1'b1;
          cand_len_next = cand_len + 1'b1;
        end
        state_next = S_SCAN_NXT;
      end
      S_R_C: begin
        if (!queued_rdata && (comm_val != best) && (q_len < CNT_W'(NODES))) begin
          queue_we     = 1'b1;
          queue_waddr  = q_head + q_len[NODE_W-1:0];
          queue_wdata  = tc;
          q_len_next   = q_len + 1'b1;
          queued_we    = 1'b1;
          queued_waddr = tc;
          queued_wdata = 1'b1;
        end
        state_next = S_SCAN_NXT;
      end
      S_SC0: begin
        etc_raddr      = cur;
        cw_raddr       = cur;
        seen_raddr     = cur;
        cur_phase_next = 1'b1;
        state_next     = S_SC1;
      end
      S_SC1: begin
        mcount_next  = (!cur_phase || seen_rdata) ? etc_rdata : '0;
        mweight_next = cw_rdata;
        state_next   = S_SC2;
      end
      S_SC2: begin
        prod_next  = PROD_W'(mweight) * PROD_W'(gamma);
        state_next = S_SC3;
      end
      S_SC3: begin
        if (cur_phase) begin
          best_score_next = score;
          best_next       = cur;
          cur_phase_next  = 1'b0;
          i_next          = '0;
        end else begin
          if ($signed({score[SCORE_W-1], score}) > thresh) begin
            best_score_next = score;
            best_next       = tc;
          end
          i_next = i + 1'b1;
        end
        state_next = S_CL_RD;
      end
      S_CL_RD: begin
        state_next = (i == cand_len) ? S_MV : S_CL_C;
      end
      S_CL_C: begin
        tc_next    = cand_rdata;
        etc_raddr  = cand_rdata;
        cw_raddr   = cand_rdata;
        seen_we    = 1'b1;
        seen_waddr = cand_rdata;
        if (cand_rdata == cur) begin
          i_next     = i + 1'b1;
          state_next = S_CL_RD;
        end else begin
          state_next = S_SC1;
        end
      end
      S_MV: begin
        state_next = (best == cur) ? S_POP : S_MV1;
      end
      S_MV1: begin
        cw_we      = 1'b1;
        cw_wdata   = cw_rdata - ndeg;
        state_next = S_MV2;
      end
      S_MV2: begin
        cw_raddr   = best;
        state_next = S_MV3;
      end
      S_MV3: begin
        cw_we      = 1'b1;
        cw_waddr   = best;
        cw_wdata   = cw_rdata + ndeg;
        comm_we    = 1'b1;
        if (moves != 16'hFFFF) moves_next = moves + 1'b1;
        k_next     = '0;
        rq_next    = 1'b1;
        state_next = S_SCAN_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `include "graph_local_moving_community_core_assert.svh"

  `GLMC_ASSERT(a_ready_idle, s_tready |-> (state == S_IDLE), "input ready outside idle")
  `GLMC_ASSERT(a_qlen_bound, q_len <= CNT_W'(NODES), "queue length beyond node count")
  `GLMC_ASSERT(a_cand_bound, cand_len <= CNT_W'(NODES), "candidate count beyond node count")
  `GLMC_ASSERT(a_edge_bound, edge_total <= ETOT_W'(EDGES), "edge total beyond store size")
  `GLMC_ASSERT_NEXT(a_query_done, state == S_QRY, state == S_DONE, "query did not finish")
endmodule
`default_nettype wire
